// File: design/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Types, codes and fixed widths shared by the seek scheduler files.
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

	localparam int TRACK_BITS     = 16;
	localparam int MAX_REQUESTERS = 16;
	localparam int ID_W           = 4;
	localparam int CAP_W          = 4;
	localparam int LIVE_W         = 5;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 5;

	localparam logic [LIVE_W-1:0] ID_LIMIT = LIVE_W'(MAX_REQUESTERS);

	localparam logic OP_SUBMIT = 1'b0;
	localparam logic OP_RETIRE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_REQUESTERS = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_PENDING  = 3'd2,
		ST_RETIRED  = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_EMIT      = 4'd0,
		S_IDLE      = 4'd1,
		S_DECODE    = 4'd2,
		S_ROUTE     = 4'd3,
		S_FREE      = 4'd4,
		S_INSERT    = 4'd5,
		S_SRV_INIT  = 4'd6,
		S_SRV_PRIME = 4'd7,
		S_SCAN      = 4'd8,
		S_TAKE      = 4'd9
	} step_t;

	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_LOAD,
		ACT_DECODE,
		ACT_PTR_CLEAR,
		ACT_FREE_STEP,
		ACT_INSERT,
		ACT_SRV_INIT,
		ACT_SCAN_ADV,
		ACT_SCAN_CMP,
		ACT_SERVE,
		ACT_EMIT
	} act_t;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_REQ,
		COND_REJECT,
		COND_RETIRE,
		COND_SLOT_BUSY,
		COND_NO_SERVE,
		COND_SCAN_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic reject;
		logic retire;
		logic slot_busy;
		logic no_serve;
		logic scan_more;
		logic out_busy;
	} flags_t;

endpackage

`default_nettype wire

// File: design/sstf_ifs.sv
// ----------------------------------------------------------------------------
// sstf interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sstf_req_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [sstf_pkg::ID_W-1:0]         requester_id;
	logic [sstf_pkg::TRACK_BITS-1:0]   track;

	modport source (output valid, opcode, requester_id, track, input ready);
	modport sink (input valid, opcode, requester_id, track, output ready);
endinterface

interface sstf_rsp_if;
	logic                              valid;
	logic                              ready;
	sstf_pkg::status_t                 status;
	logic                              served_valid;
	logic [sstf_pkg::ID_W-1:0]         served_requester;
	logic [sstf_pkg::TRACK_BITS-1:0]   served_track;
	logic [sstf_pkg::CAP_W-1:0]        queue_count;
	logic                              finished;

	modport source (output valid, status, served_valid, served_requester, served_track,
		queue_count, finished, input ready);
	modport sink (input valid, status, served_valid, served_requester, served_track,
		queue_count, finished, output ready);
endinterface

interface sstf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [sstf_pkg::CFG_IDX_W-1:0]    index;
	logic [sstf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/sstf_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Shortest-seek-first disk request scheduler driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | opcode, requester_id, track
//  rsp     | out | status, served_valid, served_requester, served_track,
//          |     | queue_count, finished
//  cfg     | in  | index, data (register writes, always ready)
//
// a refused request goes from decode straight to the result; a retire without
// serve passes route and serve init; a submit also steps over each occupied slot
// below the first free one and inserts. a serve scans the slot memory through its
// single read port, one slot and one distance compare per cycle
// one request at a time; req is ready only while the sequencer is idle
// a held result stalls the sequencer until taken; no clearing pass after reset
`default_nettype none

module sstf_disk_request_scheduler #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sstf_req_if.sink   req,
	sstf_rsp_if.source rsp,
	sstf_cfg_if.sink   cfg
);
	import sstf_pkg::*;

	ctl_t   ctl;
	flags_t flags;

	sstf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	sstf_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

`default_nettype wire

// File: design/sstf_sequencer.sv
// ----------------------------------------------------------------------------
// sstf_sequencer
// Step counter and control store; conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sstf_pkg::flags_t flags,
	output sstf_pkg::ctl_t        ctl
);
	import sstf_pkg::*;

	step_t upc_q;
	step_t upc_d;
	logic  take;

	// control store
	always_comb begin
		case (upc_q)
			S_EMIT:      ctl = '{ACT_EMIT,      COND_OUT_BUSY,  S_EMIT};
			S_IDLE:      ctl = '{ACT_LOAD,      COND_NO_REQ,    S_IDLE};
			S_DECODE:    ctl = '{ACT_DECODE,    COND_REJECT,    S_EMIT};
			S_ROUTE:     ctl = '{ACT_PTR_CLEAR, COND_RETIRE,    S_SRV_INIT};
			S_FREE:      ctl = '{ACT_FREE_STEP, COND_SLOT_BUSY, S_FREE};
			S_INSERT:    ctl = '{ACT_INSERT,    COND_NEVER,     S_IDLE};
			S_SRV_INIT:  ctl = '{ACT_SRV_INIT,  COND_NO_SERVE,  S_EMIT};
			S_SRV_PRIME: ctl = '{ACT_SCAN_ADV,  COND_NEVER,     S_IDLE};
			S_SCAN:      ctl = '{ACT_SCAN_CMP,  COND_SCAN_MORE, S_SCAN};
			S_TAKE:      ctl = '{ACT_SERVE,     COND_ALWAYS,    S_EMIT};
			default:     ctl = '{ACT_NOP,       COND_ALWAYS,    S_IDLE};
		endcase
	end

	always_comb begin
		case (ctl.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_REQ:    take = !flags.in_valid;
			COND_REJECT:    take = flags.reject;
			COND_RETIRE:    take = flags.retire;
			COND_SLOT_BUSY: take = flags.slot_busy;
			COND_NO_SERVE:  take = flags.no_serve;
			COND_SCAN_MORE: take = flags.scan_more;
			COND_OUT_BUSY:  take = flags.out_busy;
			default:        take = 1'b1;
		endcase
		upc_d = take ? ctl.target : step_t'(upc_q + 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

// File: design/sstf_datapath.sv
// ----------------------------------------------------------------------------
// sstf_datapath
// Slot memory, pending marks, head, counters, distance compare, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_datapath #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sstf_pkg::ctl_t   ctl,
	output sstf_pkg::flags_t      flags,
	sstf_req_if.sink              req,
	sstf_rsp_if.source            rsp,
	sstf_cfg_if.sink              cfg
);
	import sstf_pkg::*;

	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

	typedef struct packed {
		logic [ID_W-1:0]       owner;
		logic [TRACK_BITS-1:0] track;
	} slot_t;

	slot_t slot_mem [QUEUE_DEPTH];
	slot_t rd_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic [QUEUE_DEPTH-1:0]    slot_valid_q;
	logic [MAX_REQUESTERS-1:0] pending_q;
	logic [TRACK_BITS-1:0]     head_q;
	logic [LIVE_W-1:0]         live_q;
	logic [CAP_W-1:0]          cap_q;
	logic [CAP_W-1:0]          waiting_q;
	logic [SLOT_W-1:0]         ptr_q;

	logic                  op_q;
	logic [ID_W-1:0]       id_q;
	logic [TRACK_BITS-1:0] trk_q;

	status_t               status_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     best_idx_q;
	logic [TRACK_BITS-1:0] best_dist_q;
	logic [TRACK_BITS-1:0] best_trk_q;
	logic [ID_W-1:0]       best_own_q;
	logic                  srv_valid_q;
	logic [ID_W-1:0]       srv_req_q;
	logic [TRACK_BITS-1:0] srv_trk_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic                  out_srv_q;
	logic [ID_W-1:0]       out_req_q;
	logic [TRACK_BITS-1:0] out_trk_q;
	logic [CAP_W-1:0]      out_count_q;
	logic                  out_fin_q;

	status_t               dec_status;
	logic                  dec_reject;
	logic [TRACK_BITS-1:0] seek_gap;
	logic [LIVE_W-1:0]     live_dec;
	logic [SLOT_W-1:0]     ptr_inc;
	logic                  out_busy;
	logic                  emit_load;
	logic [CAP_W-1:0]      cfg_cap;
	logic [LIVE_W-1:0]     cfg_live;

	assign req.ready = (ctl.act == ACT_LOAD);
	assign cfg.ready = 1'b1;

	assign live_dec = live_q - LIVE_W'(1);
	assign ptr_inc  = (ptr_q != LAST_SLOT) ? ptr_q + SLOT_W'(1) : ptr_q;
	assign seek_gap = (rd_s1.track >= head_q) ? rd_s1.track - head_q : head_q - rd_s1.track;
	assign out_busy = out_valid_q && !rsp.ready;
	assign emit_load = (ctl.act == ACT_EMIT) && !out_busy;

	assign cfg_cap  = (32'(cfg.data[CAP_W-1:0]) > QUEUE_DEPTH) ? CAP_W'(QUEUE_DEPTH)
		: cfg.data[CAP_W-1:0];
	assign cfg_live = (cfg.data > ID_LIMIT) ? ID_LIMIT : cfg.data;

	// item classification
	always_comb begin
		dec_status = ST_ACCEPTED;
		dec_reject = 1'b0;
		if ({1'b0, id_q} >= ID_LIMIT) begin
			dec_status = ST_INVALID;
			dec_reject = 1'b1;
		end else if (op_q == OP_SUBMIT) begin
			if (waiting_q >= cap_q) begin
				dec_status = ST_FULL;
				dec_reject = 1'b1;
			end else if (pending_q[id_q]) begin
				dec_status = ST_PENDING;
				dec_reject = 1'b1;
			end
		end else begin
			dec_status = ST_RETIRED;
			if (pending_q[id_q]) begin
				dec_status = ST_PENDING;
				dec_reject = 1'b1;
			end else if (live_q == '0) begin
				dec_status = ST_INVALID;
				dec_reject = 1'b1;
			end
		end
	end

	always_comb begin
		flags.in_valid  = req.valid;
		flags.reject    = dec_reject;
		flags.retire    = (op_q == OP_RETIRE);
		flags.slot_busy = slot_valid_q[ptr_q];
		flags.no_serve  = (waiting_q == '0) || (waiting_q < cap_q);
		flags.scan_more = (idx_s1 != LAST_SLOT);
		flags.out_busy  = out_busy;
	end

	// slot memory, one read port scanned by ptr_q
	always_ff @(posedge clk) begin
		if (ctl.act == ACT_INSERT) begin
			slot_mem[ptr_q] <= '{owner: id_q, track: trk_q};
		end
		rd_s1  <= slot_mem[ptr_q];
		idx_s1 <= ptr_q;
	end

	// item latch, scan payload, status and result registers
	always_ff @(posedge clk) begin
		if (ctl.act == ACT_LOAD && req.valid) begin
			op_q  <= req.opcode;
			id_q  <= req.requester_id;
			trk_q <= req.track;
		end
		if (ctl.act == ACT_SCAN_CMP && slot_valid_q[idx_s1]
				&& (!found_q || seek_gap < best_dist_q)) begin
			best_idx_q  <= idx_s1;
			best_dist_q <= seek_gap;
			best_trk_q  <= rd_s1.track;
			best_own_q  <= rd_s1.owner;
		end
		if (ctl.act == ACT_DECODE) begin
			status_q  <= dec_status;
			srv_req_q <= '0;
			srv_trk_q <= '0;
		end
		if (ctl.act == ACT_SERVE && found_q) begin
			srv_req_q <= best_own_q;
			srv_trk_q <= best_trk_q;
		end
		if (emit_load) begin
			out_status_q <= status_q;
			out_srv_q    <= srv_valid_q;
			out_req_q    <= srv_req_q;
			out_trk_q    <= srv_trk_q;
			out_count_q  <= waiting_q;
			out_fin_q    <= (cap_q == '0);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			pending_q    <= '0;
			head_q       <= '0;
			live_q       <= LIVE_W'(1);
			cap_q        <= CAP_W'(1);
			waiting_q    <= '0;
			ptr_q        <= '0;
			found_q      <= 1'b0;
			srv_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.index == REG_MAX_QUEUE) begin
				cap_q <= cfg_cap;
			end
			if (cfg.valid && cfg.index == REG_NUM_REQUESTERS) begin
				live_q <= cfg_live;
			end
			case (ctl.act)
				ACT_DECODE: begin
					srv_valid_q <= 1'b0;
					if (!dec_reject && op_q == OP_RETIRE) begin
						live_q <= live_dec;
						if (live_dec < {1'b0, cap_q}) begin
							cap_q <= cap_q - CAP_W'(1);
						end
					end
				end
				ACT_PTR_CLEAR: ptr_q <= '0;
				ACT_FREE_STEP: begin
					if (slot_valid_q[ptr_q]) begin
						ptr_q <= ptr_inc;
					end
				end
				ACT_INSERT: begin
					slot_valid_q[ptr_q] <= 1'b1;
					pending_q[id_q]     <= 1'b1;
					waiting_q           <= waiting_q + CAP_W'(1);
				end
				ACT_SRV_INIT: begin
					ptr_q   <= '0;
					found_q <= 1'b0;
				end
				ACT_SCAN_ADV: ptr_q <= ptr_inc;
				ACT_SCAN_CMP: begin
					ptr_q <= ptr_inc;
					if (slot_valid_q[idx_s1]) begin
						found_q <= 1'b1;
					end
				end
				ACT_SERVE: begin
					if (found_q) begin
						slot_valid_q[best_idx_q] <= 1'b0;
						pending_q[best_own_q]    <= 1'b0;
						head_q                   <= best_trk_q;
						waiting_q                <= waiting_q - CAP_W'(1);
						srv_valid_q              <= 1'b1;
					end
				end
				default: ;
			endcase
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.served_valid     = out_srv_q;
	assign rsp.served_requester = out_req_q;
	assign rsp.served_track     = out_trk_q;
	assign rsp.queue_count      = out_count_q;
	assign rsp.finished         = out_fin_q;

`ifndef SYNTHESIS
	a_count_matches_slots: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == int'(waiting_q))
		else $error("waiting count differs from occupied slots");

	a_count_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		int'(waiting_q) <= QUEUE_DEPTH)
		else $error("waiting count beyond queue depth");

	a_serve_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == ACT_SERVE && found_q) |=> (head_q == srv_trk_q && srv_valid_q))
		else $error("serve did not move head to served track");

	a_served_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_srv_q) |-> (out_status_q == ST_ACCEPTED
			|| out_status_q == ST_RETIRED))
		else $error("serve reported on a refused request");
`endif

endmodule

`default_nettype wire

// File: tb/sv/sstf_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sstf_scheduler_checker
// Watches the request, result and register write channels of the seek
// scheduler, keeps its own copy of the queue, head and requester state,
// works out the result of every accepted request and compares each result
// field against it in order of arrival.
// ----------------------------------------------------------------------------

module sstf_scheduler_checker #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	sstf_req_if  req,
	sstf_rsp_if  rsp,
	sstf_cfg_if  cfg,
	output int   fail_count,
	output int   results_due,
	output int   requests_seen,
	output int   serves_seen,
	output int   writes_seen
);

	import sstf_pkg::*;

	typedef struct packed {
		status_t                status;
		logic                   served_valid;
		logic [ID_W-1:0]        served_requester;
		logic [TRACK_BITS-1:0]  served_track;
		logic [CAP_W-1:0]       queue_count;
		logic                   finished;
	} sched_result_t;

	logic                   slot_used [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0]  slot_trk  [QUEUE_DEPTH];
	logic [ID_W-1:0]        slot_id   [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0]  head_pos;
	logic                   id_waiting [MAX_REQUESTERS];
	logic [LIVE_W-1:0]      live_left;
	logic [CAP_W-1:0]       cap_now;
	logic [CAP_W-1:0]       queued;

	sched_result_t expected_results [$];

	function automatic logic [CAP_W-1:0] clamp_cap(input logic [CFG_DATA_W-1:0] v);
		logic [3:0] q;
		q = v[3:0];
		return (q > QUEUE_DEPTH) ? CAP_W'(QUEUE_DEPTH) : CAP_W'(q);
	endfunction

	function automatic logic [LIVE_W-1:0] clamp_live(input logic [CFG_DATA_W-1:0] v);
		return (v > MAX_REQUESTERS) ? LIVE_W'(MAX_REQUESTERS) : LIVE_W'(v);
	endfunction

	// serve the waiting request nearest the head once the queue is at capacity
	function automatic void serve_nearest(inout sched_result_t r);
		int                    pick;
		logic [TRACK_BITS-1:0] gap;
		logic [TRACK_BITS-1:0] best;
		pick = -1;
		best = '0;
		if (queued == 0 || queued < cap_now)
			return;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (slot_used[i]) begin
				gap = (slot_trk[i] >= head_pos) ? slot_trk[i] - head_pos : head_pos - slot_trk[i];
				if (pick < 0 || gap < best) begin
					pick = i;
					best = gap;
				end
			end
		end
		if (pick < 0)
			return;
		r.served_valid     = 1'b1;
		r.served_requester = slot_id[pick];
		r.served_track     = slot_trk[pick];
		slot_used[pick]    = 1'b0;
		id_waiting[slot_id[pick]] = 1'b0;
		head_pos = slot_trk[pick];
		queued   = queued - CAP_W'(1);
	endfunction

	function automatic sched_result_t predict_outcome(input logic op, input logic [ID_W-1:0] id,
		input logic [TRACK_BITS-1:0] trk);
		sched_result_t r;
		int            free_at;
		r = '0;
		if ({1'b0, id} >= ID_LIMIT) begin
			r.status = ST_INVALID;
		end else if (op == OP_SUBMIT) begin
			if (queued >= cap_now) begin
				r.status = ST_FULL;
			end else if (id_waiting[id]) begin
				r.status = ST_PENDING;
			end else begin
				free_at = -1;
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (!slot_used[i] && free_at < 0)
						free_at = i;
				if (free_at < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_used[free_at] = 1'b1;
					slot_trk[free_at]  = trk;
					slot_id[free_at]   = id;
					id_waiting[id]     = 1'b1;
					queued   = queued + CAP_W'(1);
					r.status = ST_ACCEPTED;
					serve_nearest(r);
				end
			end
		end else begin
			if (id_waiting[id]) begin
				r.status = ST_PENDING;
			end else if (live_left == 0) begin
				r.status = ST_INVALID;
			end else begin
				live_left = live_left - LIVE_W'(1);
				if (live_left < cap_now)
					cap_now = cap_now - CAP_W'(1);
				r.status = ST_RETIRED;
				serve_nearest(r);
			end
		end
		r.queue_count = queued;
		r.finished    = (cap_now == 0);
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sched_result_t want;
		sched_result_t fresh;
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				slot_used[i] = 1'b0;
				slot_trk[i]  = '0;
				slot_id[i]   = '0;
			end
			for (int i = 0; i < MAX_REQUESTERS; i++)
				id_waiting[i] = 1'b0;
			head_pos  = '0;
			live_left = clamp_live(CFG_DATA_W'(1));
			cap_now   = clamp_cap(CFG_DATA_W'(1));
			queued    = '0;
			expected_results.delete();
			fail_count    = 0;
			results_due   = 0;
			requests_seen = 0;
			serves_seen   = 0;
			writes_seen   = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no request waiting for it");
					fail_count++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					compare_field("status", want.status, rsp.status);
					compare_field("served_valid", want.served_valid, rsp.served_valid);
					compare_field("served_requester", want.served_requester,
						rsp.served_requester);
					compare_field("served_track", want.served_track, rsp.served_track);
					compare_field("queue_count", want.queue_count, rsp.queue_count);
					compare_field("finished", want.finished, rsp.finished);
				end
			end
			if (cfg.valid && cfg.ready) begin
				writes_seen++;
				if (cfg.index == REG_MAX_QUEUE)
					cap_now = clamp_cap(cfg.data);
				else if (cfg.index == REG_NUM_REQUESTERS)
					live_left = clamp_live(cfg.data);
			end
			if (req.valid && req.ready) begin
				fresh = predict_outcome(req.opcode, req.requester_id, req.track);
				expected_results.insert(expected_results.size(), fresh);
				requests_seen++;
				if (fresh.served_valid)
					serves_seen++;
			end
			results_due = expected_results.size();
		end
	end

endmodule

// File: tb/sv/tb_sstf_disk_request_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sstf_disk_request_scheduler
// Drives the seek scheduler with a directed opening (corner tracks, ties,
// duplicate and retiring requesters, zero and saturating register values)
// followed by random phases under new register settings, with random idle
// and stall cycles and one long result hold-off. A side checker predicts and
// compares every result; this module produces stimulus and the verdict.
// ----------------------------------------------------------------------------

module tb_sstf_disk_request_scheduler;

	import sstf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int fail_count;
	int results_due;
	int requests_seen;
	int serves_seen;
	int writes_seen;

	int   cycle_count = 0;
	int   items_sent  = 0;
	logic calm        = 1'b0;
	logic [CFG_DATA_W-1:0] requesters_set = CFG_DATA_W'(1);

	sstf_req_if req ();
	sstf_rsp_if rsp ();
	sstf_cfg_if cfg ();

	sstf_disk_request_scheduler #(
		.QUEUE_DEPTH(8)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	sstf_scheduler_checker #(
		.QUEUE_DEPTH(8)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.cfg           (cfg),
		.fail_count    (fail_count),
		.results_due   (results_due),
		.requests_seen (requests_seen),
		.serves_seen   (serves_seen),
		.writes_seen   (writes_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, a calm stretch, and one long hold-off
	initial begin : result_side
		int   hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= calm || ($urandom_range(99) >= 6);
			end
		end
	end

	function automatic logic [TRACK_BITS-1:0] pick_track();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return TRACK_BITS'($urandom);
		if (roll < 80)
			return TRACK_BITS'($urandom_range(15));
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return TRACK_BITS'(16'h8000);
			default: return TRACK_BITS'(16'h7fff);
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_requester();
		int unsigned top_id;
		top_id = (requesters_set > MAX_REQUESTERS) ? MAX_REQUESTERS : requesters_set;
		if (top_id != 0 && $urandom_range(99) < 80)
			return ID_W'($urandom_range(top_id - 1));
		return ID_W'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_capacity();
		int unsigned roll;
		logic [3:0]  q;
		roll = $urandom_range(99);
		if (roll < 80)
			q = 4'($urandom_range(8, 1));
		else if (roll < 90)
			q = 4'd0;
		else
			q = 4'($urandom_range(15, 9));
		return {1'($urandom), q};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_population();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return CFG_DATA_W'($urandom_range(16, 1));
		if (roll < 90)
			return '0;
		return CFG_DATA_W'($urandom_range(31, 17));
	endfunction

	task automatic offer_request(input logic op, input logic [ID_W-1:0] id,
		input logic [TRACK_BITS-1:0] trk);
		if (!calm && $urandom_range(99) < 6) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.requester_id <= id;
		req.track        <= trk;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// only once every outstanding result has come back
	task automatic write_regs(input logic [CFG_DATA_W-1:0] queue_val,
		input logic [CFG_DATA_W-1:0] population_val);
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (results_due != 0);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= REG_MAX_QUEUE;
		cfg.data  <= queue_val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.index <= REG_NUM_REQUESTERS;
		cfg.data  <= population_val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		requesters_set = population_val;
	endtask

	initial begin : stimulus
		int random_sent;
		int burst;
		random_sent      = 0;
		req.valid        = 1'b0;
		req.opcode       = OP_SUBMIT;
		req.requester_id = '0;
		req.track        = '0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_MAX_QUEUE;
		cfg.data         = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one slot, one live requester
		offer_request(OP_SUBMIT, 4'd0, 16'hffff);
		offer_request(OP_SUBMIT, 4'd15, 16'h0000);
		offer_request(OP_RETIRE, 4'd3, 16'h0000);
		offer_request(OP_SUBMIT, 4'd2, 16'h1234);
		offer_request(OP_RETIRE, 4'd4, 16'h0000);

		// saturating values, equal tracks, duplicate and waiting requesters
		write_regs(5'h1f, 5'h1f);
		offer_request(OP_SUBMIT, 4'd1, 16'd100);
		offer_request(OP_SUBMIT, 4'd2, 16'd100);
		offer_request(OP_SUBMIT, 4'd1, 16'd5);
		offer_request(OP_RETIRE, 4'd2, 16'd0);
		offer_request(OP_SUBMIT, 4'd3, 16'd0);
		offer_request(OP_SUBMIT, 4'd4, 16'hffff);
		offer_request(OP_SUBMIT, 4'd5, 16'd200);
		offer_request(OP_SUBMIT, 4'd6, 16'd50);
		offer_request(OP_SUBMIT, 4'd7, 16'd150);
		offer_request(OP_SUBMIT, 4'd8, 16'd100);
		offer_request(OP_SUBMIT, 4'd9, 16'd7);

		// shrink below the queue, then zero capacity and no live requesters
		write_regs(5'h12, 5'h10);
		offer_request(OP_SUBMIT, 4'd10, 16'h5555);
		offer_request(OP_RETIRE, 4'd10, 16'haaaa);
		write_regs(5'h00, 5'h00);
		offer_request(OP_SUBMIT, 4'd11, 16'h0f0f);
		offer_request(OP_RETIRE, 4'd11, 16'h0000);
		write_regs(5'h10, 5'h01);
		offer_request(OP_RETIRE, 4'd12, 16'h0000);
		offer_request(OP_RETIRE, 4'd13, 16'h0000);

		while (random_sent < RANDOM_ITEMS) begin
			write_regs(pick_capacity(), pick_population());
			burst = $urandom_range(80, 30);
			for (int k = 0; k < burst; k++) begin
				calm = (random_sent >= 200 && random_sent < 400);
				if ($urandom_range(99) < 15)
					offer_request(OP_RETIRE, ID_W'($urandom), pick_track());
				else
					offer_request(OP_SUBMIT, pick_requester(), pick_track());
				random_sent++;
			end
		end
		calm = 1'b0;

		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (results_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d requests, %0d of which served a queued request", requests_seen,
			serves_seen);
		$display("%0d register writes, capacity and requester count swept incl. zero and overflow",
			writes_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sstf_disk_request_scheduler.f
design/sstf_pkg.sv
design/sstf_ifs.sv
design/sstf_sequencer.sv
design/sstf_datapath.sv
design/sstf_disk_request_scheduler.sv
tb/sv/sstf_scheduler_checker.sv
tb/sv/tb_sstf_disk_request_scheduler.sv
